// File: hdl/packet_attribute_histogram_core_defines.svh
// Assertion macros for the packet attribute histogram core.
// Used by the top level only; no other dependencies.
`ifndef PACKET_ATTRIBUTE_HISTOGRAM_CORE_DEFINES_SVH
`define PACKET_ATTRIBUTE_HISTOGRAM_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset
`define PAH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property checked on every rising clock edge, reset included
`define PAH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define PAH_ASSERT(label, prop, msg)
`define PAH_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hdl/pah_pkg.sv
// Shared types and constants of the packet attribute histogram core.
// No dependencies.
`default_nettype none

package pah_pkg;

   // Bin index width: covers read_bin and every bin the modes can produce
   localparam int BIN_W = 11;
   localparam int CNT_W = 32;

   typedef enum logic [1:0] {
      MODE_SIZE      = 2'd0,
      MODE_DIRECTION = 2'd1,
      MODE_FREQUENCY = 2'd2,
      MODE_OFFSET    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_OBSERVE = 2'd0,
      OP_READ    = 2'd1,
      OP_CLEAR   = 2'd2
   } opcode_type;

   // Bin selection handed from the bin mapper to the core
   typedef struct packed {
      logic             count;     // observation adds to a bin
      logic             in_range;  // bin lies inside the store
      logic [BIN_W-1:0] bin;
   } bin_sel_type;

endpackage

`default_nettype wire

// File: hdl/pah_bin_map.sv
// Maps one transaction onto a histogram bin according to the attribute mode.
// Depends on pah_pkg.
`default_nettype none

module pah_bin_map
   import pah_pkg::*;
#(
   parameter int NUM_BINS      = 2048,
   parameter int SIZE_LIMIT    = 1500,
   parameter int OFFSET_WINDOW = 128
) (
   input  wire mode_type          mode,
   input  wire opcode_type        opcode,
   input  wire logic [7:0]        data_byte,
   input  wire logic [15:0]       byte_position,
   input  wire logic              first_of_packet,
   input  wire logic [15:0]       packet_length,
   input  wire logic              direction,
   input  wire logic [BIN_W-1:0]  read_bin,
   output bin_sel_type            sel
);

   localparam logic [15:0] SIZE_CAP = 16'(SIZE_LIMIT - 1);

   logic [BIN_W-1:0] obs_bin;
   logic             obs_hit;
   logic [BIN_W-1:0] pick_bin;

   // Bin and eligibility of an observed byte
   always_comb begin
      obs_bin = '0;
      obs_hit = 1'b0;
      unique case (mode)
         MODE_SIZE: begin
            obs_hit = first_of_packet;
            obs_bin = (packet_length >= 16'(SIZE_LIMIT)) ? BIN_W'(SIZE_CAP)
                                                        : BIN_W'(packet_length);
         end
         MODE_DIRECTION: begin
            obs_hit = first_of_packet;
            obs_bin = BIN_W'(direction);
         end
         MODE_FREQUENCY: begin
            obs_hit = 1'b1;
            obs_bin = BIN_W'(data_byte);
         end
         MODE_OFFSET: begin
            // even bin for a nonzero byte, odd bin for a zero byte
            obs_hit = (byte_position < 16'(OFFSET_WINDOW));
            obs_bin = {byte_position[BIN_W-2:0], ~|data_byte};
         end
         default: begin
            obs_hit = 1'b0;
            obs_bin = '0;
         end
      endcase
   end

   assign pick_bin     = (opcode == OP_READ) ? read_bin : obs_bin;
   assign sel.bin      = pick_bin;
   assign sel.in_range = (int'(pick_bin) < NUM_BINS);
   assign sel.count    = (opcode == OP_OBSERVE) && obs_hit && sel.in_range;

endmodule

`default_nettype wire

// File: hdl/packet_attribute_histogram_core.sv
// Top level of the packet attribute histogram core: bin store, total, clear sweep.
// Depends on pah_pkg, pah_bin_map and packet_attribute_histogram_core_defines.svh.
//
//   channel   dir  tdata fields (low bit up)                          tuser
//   req_      in   data_byte, byte_position, packet_length,           opcode, first_of_packet
//                  direction, read_bin
//   rsp_      out  bin_count, total_count                             -
//   csr_      in   attribute_mode                                     -
//
// One transaction per cycle while req_tready is high: each observe does a
// read-modify-write of one store entry (registered memory read into stage 1,
// then write back from stage 1), with the last write forwarded to the following
// read of the same entry. After reset the store is swept to zero, one entry per
// cycle, over all NUM_BINS entries; a clear holds req_tready low at stage 1 and
// through the sweep. A read at stage 1 behind an untaken response holds it low.
`default_nettype none
`include "packet_attribute_histogram_core_defines.svh"

module packet_attribute_histogram_core
   import pah_pkg::*;
#(
   parameter int NUM_BINS      = 2048,
   parameter int SIZE_LIMIT    = 1500,
   parameter int OFFSET_WINDOW = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = data_byte[7:0], byte_position[23:8], packet_length[39:24],
   //          direction[40], read_bin[51:41], zero[55:52]
   //          tuser = opcode[1:0], first_of_packet[2]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic [2:0]  req_tuser,
   // response: tdata = bin_count[31:0], total_count[63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,
   // register write: tdata = attribute_mode[1:0], zero[7:2]
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   input  wire logic [7:0]  csr_tdata
);

   localparam int ADDR_W = $clog2(NUM_BINS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

   // store
   logic [CNT_W-1:0] bin_mem [NUM_BINS];

   // configuration
   mode_type mode_ff;

   // request decode
   opcode_type       req_op;
   bin_sel_type      req_sel;
   logic [ADDR_W-1:0] req_addr;
   logic             req_accept;

   // stage 1 (memory data available)
   logic              s1_valid_ff;
   opcode_type        s1_op_ff;
   bin_sel_type       s1_sel_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [CNT_W-1:0]  rd_data_ff;
   logic              fwd_ff;
   logic [CNT_W-1:0]  fwd_data_ff;
   logic [CNT_W-1:0]  s1_cur;
   logic [CNT_W-1:0]  s1_new;
   logic              s1_adv;
   logic              s1_wr;
   logic              s1_read;
   logic              clr_start;

   // total and clear sweep
   logic [CNT_W-1:0]  total_ff;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // response register
   logic              rsp_valid_ff;
   logic [63:0]       rsp_data_ff;

   // configuration port is always ready
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SIZE;
      end else if (csr_tvalid) begin
         mode_ff <= mode_type'(csr_tdata[1:0]);
      end
   end

   // bin selection for the incoming transaction
   assign req_op = opcode_type'(req_tuser[1:0]);

   pah_bin_map #(
      .NUM_BINS      (NUM_BINS),
      .SIZE_LIMIT    (SIZE_LIMIT),
      .OFFSET_WINDOW (OFFSET_WINDOW)
   ) u_bin_map (
      .mode            (mode_ff),
      .opcode          (req_op),
      .data_byte       (req_tdata[7:0]),
      .byte_position   (req_tdata[23:8]),
      .first_of_packet (req_tuser[2]),
      .packet_length   (req_tdata[39:24]),
      .direction       (req_tdata[40]),
      .read_bin        (req_tdata[51:41]),
      .sel             (req_sel)
   );

   assign req_addr = ADDR_W'(req_sel.bin);

   // stage 1 control
   assign s1_read   = s1_valid_ff && (s1_op_ff == OP_READ);
   assign s1_adv    = !s1_read || !rsp_valid_ff || rsp_tready;
   assign s1_wr     = s1_valid_ff && s1_sel_ff.count;
   assign clr_start = s1_valid_ff && (s1_op_ff == OP_CLEAR);

   // no new transaction while sweeping or while a clear sits at stage 1
   assign req_tready = !clr_busy_ff && !clr_start && s1_adv;
   assign req_accept = req_tvalid && req_tready;

   // current bin value, with the previous write forwarded
   assign s1_cur = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign s1_new = (s1_cur == CNT_MAX) ? s1_cur : s1_cur + 1'b1;

   // stage 1 registers and forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= req_accept;
         end
         if (req_accept) begin
            fwd_ff <= s1_wr && (s1_addr_ff == req_addr);
         end
      end
      if (req_accept) begin
         s1_op_ff    <= req_op;
         s1_sel_ff   <= req_sel;
         s1_addr_ff  <= req_addr;
         fwd_data_ff <= s1_new;
      end
   end

   // memory: one read port, one write port shared by updates and the sweep
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= bin_mem[req_addr];
      end
      if (clr_busy_ff) begin
         bin_mem[clr_addr_ff] <= '0;
      end else if (s1_wr) begin
         bin_mem[s1_addr_ff] <= s1_new;
      end
   end

   // running total and clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         if (clr_start) begin
            total_ff    <= '0;
            clr_busy_ff <= 1'b1;
            clr_addr_ff <= '0;
         end else begin
            if (s1_wr && (total_ff != CNT_MAX)) begin
               total_ff <= total_ff + 1'b1;
            end
            if (clr_busy_ff) begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_ADDR) begin
                  clr_busy_ff <= 1'b0;
               end
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_read && s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_read && s1_adv) begin
         rsp_data_ff <= {total_ff, (s1_sel_ff.in_range ? s1_cur : CNT_W'(0))};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `PAH_ASSERT(a_no_accept_in_sweep, clr_busy_ff |-> !req_tready, "accept during clear sweep")
   `PAH_ASSERT(a_sweep_excludes_update, clr_busy_ff |-> !s1_wr, "bin update during clear sweep")
   `PAH_ASSERT(a_total_monotonic, !clr_start |=> (total_ff >= $past(total_ff)), "total decreased without clear")
   `PAH_ASSERT_ALWAYS(a_sweep_after_reset, reset |=> (clr_busy_ff && !rsp_tvalid), "no sweep after reset")

endmodule

`default_nettype wire
